// ===== rtl/rktd_pkg.sv =====
// Shared types and constants for the rolling-key TEA decryptor.
// Used by rktd_key, rktd_cell and rolling_key_tea_decrypt; depends on nothing.
`default_nettype none

package rktd_pkg;

	// TEA constants
	localparam logic [31:0] TEA_DELTA     = 32'h9E37_79B9;
	localparam logic [31:0] TEA_SUM_START = 32'hC6EF_3720;
	localparam int unsigned TEA_ROUNDS    = 32;
	// two half-round cells per round
	localparam int unsigned NUM_CELLS     = 2 * TEA_ROUNDS;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_INIT_KEY_0 = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_KEY_1 = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_KEY_2 = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_KEY_3 = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DRIFT_0    = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DRIFT_1    = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DRIFT_2    = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DRIFT_3    = 4'd7;

	// register reset values
	localparam logic [3:0][31:0] INIT_KEY_RST = {
		32'h7654_3210, 32'hFEDC_BA98, 32'h89AB_CDEF, 32'h0123_4567
	};
	localparam logic [3:0][31:0] DRIFT_RST = {
		32'h3344_5566, 32'hCDEF_1122, 32'h5678_90AB, 32'h1234_1234
	};

	typedef logic [3:0][31:0] key_t;

	// input request
	typedef struct packed {
		logic        first_block;
		logic [31:0] cipher_hi;
		logic [31:0] cipher_lo;
	} cipher_t;

	// output request
	typedef struct packed {
		logic [31:0] plain_hi;
		logic [31:0] plain_lo;
	} plain_t;

	// word pair and key handed from cell to cell;
	// q is the word that the next cell updates from p
	typedef struct packed {
		logic [31:0] p;
		logic [31:0] q;
		key_t        key;
	} stage_t;

endpackage

`default_nettype wire

// ===== rtl/rktd_key.sv =====
// Configuration registers and running key schedule of the TEA decryptor.
// Depends on rktd_pkg.
`default_nettype none

module rktd_key (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [rktd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rktd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                          take,
	input  wire logic                          first_block,
	input  wire logic [31:0]                   cipher_hi,
	input  wire logic [31:0]                   cipher_lo,
	output rktd_pkg::key_t                     key_use
);
	import rktd_pkg::*;

	key_t init_key_q;
	key_t drift_q;
	key_t run_key_q;

	// pick the key for the request at hand
	assign key_use = first_block ? init_key_q : run_key_q;

	// decode configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_key_q <= INIT_KEY_RST;
			drift_q    <= DRIFT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INIT_KEY_0: init_key_q[0] <= cfg_data;
				REG_INIT_KEY_1: init_key_q[1] <= cfg_data;
				REG_INIT_KEY_2: init_key_q[2] <= cfg_data;
				REG_INIT_KEY_3: init_key_q[3] <= cfg_data;
				REG_DRIFT_0:    drift_q[0]    <= cfg_data;
				REG_DRIFT_1:    drift_q[1]    <= cfg_data;
				REG_DRIFT_2:    drift_q[2]    <= cfg_data;
				REG_DRIFT_3:    drift_q[3]    <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance the running key by drift plus ciphertext on every request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_key_q <= '0;
		end else if (take) begin
			run_key_q[0] <= key_use[0] + drift_q[0] + cipher_hi;
			run_key_q[1] <= key_use[1] + drift_q[1] + cipher_lo;
			run_key_q[2] <= key_use[2] + drift_q[2] + cipher_hi;
			run_key_q[3] <= key_use[3] + drift_q[3] + cipher_lo;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rktd_cell.sv =====
// One TEA half-round cell: updates one word from the other and hands the pair on.
// Depends on rktd_pkg.
`default_nettype none

module rktd_cell #(
	parameter logic [31:0] SUM    = 32'hC6EF_3720,
	parameter bit          KEY_HI = 1'b1
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       advance,
	input  wire logic       valid_i,
	input  wire rktd_pkg::stage_t data_i,
	output logic            valid_o,
	output rktd_pkg::stage_t data_o
);
	import rktd_pkg::*;

	logic [31:0] ka;
	logic [31:0] kb;
	logic [31:0] mix;
	stage_t      nxt;

	// first half of a round uses key words 2 and 3, second half 0 and 1
	assign ka = KEY_HI ? data_i.key[2] : data_i.key[0];
	assign kb = KEY_HI ? data_i.key[3] : data_i.key[1];

	assign mix = ((data_i.p << 4) + ka) ^ (data_i.p + SUM) ^ ((data_i.p >> 5) + kb);

	// swap roles: the updated word drives the next cell
	always_comb begin
		nxt     = data_i;
		nxt.p   = data_i.q - mix;
		nxt.q   = data_i.p;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (advance) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_o <= nxt;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rolling_key_tea_decrypt.sv =====
// Top level of the rolling-key TEA decryptor: key schedule and a chain of
// 64 half-round cells. Depends on rktd_pkg, rktd_key and rktd_cell.
//
// Usage:
//   in_valid/in_stall/in_data carry one 64-bit ciphertext block per request;
//   first_block set reloads the running key from the initial-key registers.
//   out_valid/out_stall/out_data carry the matching plaintext, in order.
//   cfg_we/cfg_index/cfg_data write the key and drift registers (index 0..7,
//   higher indexes are ignored); write them only while the block is idle.
// Timing:
//   One register per half-round cell, the last of which is the output
//   register. Throughput is one block per cycle while the output is not
//   stalled: the running key is updated in the accepting cycle from the
//   previous key, the drift registers and the ciphertext only.
// Reset:
//   arst_n clears all cell valid bits and the running key, and loads the
//   register reset values.
// Back-pressure:
//   While out_valid and out_stall are both high the whole chain holds,
//   in_stall is raised and the output request stays unchanged.
`default_nettype none

module rolling_key_tea_decrypt (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire rktd_pkg::cipher_t             in_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output rktd_pkg::plain_t                   out_data,
	input  wire logic                          cfg_we,
	input  wire logic [rktd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rktd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rktd_pkg::*;

	logic   advance;
	logic   take;
	key_t   key_use;
	stage_t head;

	logic   [NUM_CELLS:0] valid_c;
	stage_t [NUM_CELLS:0] data_c;

	// hold the chain while the output request is stalled
	assign advance  = !(out_valid && out_stall);
	assign in_stall = !advance;
	assign take     = in_valid && advance;

	rktd_key u_key (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.take        (take),
		.first_block (in_data.first_block),
		.cipher_hi   (in_data.cipher_hi),
		.cipher_lo   (in_data.cipher_lo),
		.key_use     (key_use)
	);

	// feed the first cell: hi word drives the first update of lo
	always_comb begin
		head.p   = in_data.cipher_hi;
		head.q   = in_data.cipher_lo;
		head.key = key_use;
	end

	assign valid_c[0] = in_valid;
	assign data_c[0]  = head;

	// chain of half-round cells, two per round with a shared sum
	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		localparam logic [31:0] RND_SUM =
			TEA_SUM_START - TEA_DELTA * 32'(i / 2);
		rktd_cell #(
			.SUM    (RND_SUM),
			.KEY_HI ((i % 2) == 0)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.valid_i (valid_c[i]),
			.data_i  (data_c[i]),
			.valid_o (valid_c[i+1]),
			.data_o  (data_c[i+1])
		);
	end

	// last cell is the output register
	assign out_valid         = valid_c[NUM_CELLS];
	assign out_data.plain_hi = data_c[NUM_CELLS].p;
	assign out_data.plain_lo = data_c[NUM_CELLS].q;

endmodule

`default_nettype wire
